// ----- hdl/tcge_pkg.sv -----
// Package for the text cursor glyph emitter: shared types, codes and constants.
// Used by tcge_ctrl, tcge_dp and text_cursor_glyph_emitter; depends on nothing.
package tcge_pkg;

  localparam int TEXT_COLUMNS = 16;

  localparam logic       OP_PUT  = 1'b0;
  localparam logic       OP_SET  = 1'b1;
  localparam logic [7:0] CHAR_CR = 8'd13;
  localparam logic [7:0] CHAR_LF = 8'd10;
  localparam logic [7:0] CHAR_BS = 8'd8;

  localparam logic REG_TEXT_COLOUR = 1'b0;
  localparam logic REG_DOUBLE_SIZE = 1'b1;

  localparam logic [3:0] PAGE_BASE   = 4'hB;
  localparam logic [3:0] COL_HI_BASE = 4'h1;
  localparam logic [7:0] BLANK_BYTE  = 8'h00;

  typedef enum logic [2:0] {
    K_SET,
    K_CR,
    K_LF,
    K_BS,
    K_CHAR
  } kind_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_CUR_A,
    ST_BLANK,
    ST_GLYPH,
    ST_HI,
    ST_MID,
    ST_LO,
    ST_CUR_END
  } state_t;

  typedef enum logic [2:0] {
    SRC_CURSOR,
    SRC_CURSOR_NEXT,
    SRC_BLANK,
    SRC_GLYPH,
    SRC_HI,
    SRC_LO
  } byte_src_t;

  typedef struct packed {
    logic      load;
    logic      emit;
    byte_src_t src;
    logic      last;
    logic      cnt_inc;
    logic      cnt_clr;
    logic      advance;
    logic      adv_two;
  } ctl_cmd_t;

  typedef struct packed {
    kind_t      kind;
    logic       col_zero;
    logic       dbl;
    logic       out_free;
    logic [3:0] cnt;
  } ctl_stat_t;

  // Each bit of the nibble becomes two adjacent bits of the result.
  function automatic logic [7:0] dbl_nibble(input logic [3:0] n);
    logic [7:0] z;
    z = '0;
    for (int k = 0; k < 4; k++) begin
      z[2*k]   = n[k];
      z[2*k+1] = n[k];
    end
    return z;
  endfunction

endpackage

// ----- hdl/tcge_ctrl.sv -----
// Controller state machine for the text cursor glyph emitter.
// Sequences the byte phases of one item; depends on tcge_pkg.
module tcge_ctrl (
  input  logic               clk,
  input  logic               rst,
  input  logic               in_valid,
  output logic               in_ready,
  input  tcge_pkg::ctl_stat_t stat,
  output tcge_pkg::ctl_cmd_t  cmd
);

  tcge_pkg::state_t state, state_next;
  logic [3:0]       last_idx;
  logic             phase_done;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= tcge_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next  = state;
    cmd         = '0;
    cmd.src     = tcge_pkg::SRC_CURSOR;
    in_ready    = 1'b0;
    last_idx    = 4'd2;
    case (state)
      tcge_pkg::ST_CUR_A:   cmd.src = tcge_pkg::SRC_CURSOR;
      tcge_pkg::ST_BLANK: begin
        cmd.src  = tcge_pkg::SRC_BLANK;
        last_idx = 4'd7;
      end
      tcge_pkg::ST_GLYPH: begin
        cmd.src  = tcge_pkg::SRC_GLYPH;
        last_idx = 4'd7;
      end
      tcge_pkg::ST_HI: begin
        cmd.src  = tcge_pkg::SRC_HI;
        last_idx = 4'd15;
      end
      tcge_pkg::ST_MID:     cmd.src = tcge_pkg::SRC_CURSOR_NEXT;
      tcge_pkg::ST_LO: begin
        cmd.src  = tcge_pkg::SRC_LO;
        last_idx = 4'd15;
      end
      default:              cmd.src = tcge_pkg::SRC_CURSOR;
    endcase
    phase_done = (stat.cnt == last_idx);

    if (state == tcge_pkg::ST_IDLE) begin
      in_ready = 1'b1;
      if (in_valid) begin
        cmd.load    = 1'b1;
        cmd.cnt_clr = 1'b1;
        case (stat.kind)
          tcge_pkg::K_SET, tcge_pkg::K_CR, tcge_pkg::K_LF: begin
            state_next = tcge_pkg::ST_CUR_END;
          end
          tcge_pkg::K_BS: begin
            state_next = stat.col_zero ? tcge_pkg::ST_IDLE : tcge_pkg::ST_CUR_A;
          end
          default: begin
            state_next = stat.dbl ? tcge_pkg::ST_HI : tcge_pkg::ST_GLYPH;
          end
        endcase
      end
    end else if (stat.out_free) begin
      cmd.emit = 1'b1;
      if (phase_done) begin
        cmd.cnt_clr = 1'b1;
        case (state)
          tcge_pkg::ST_CUR_A:  state_next = tcge_pkg::ST_BLANK;
          tcge_pkg::ST_BLANK:  state_next = tcge_pkg::ST_CUR_END;
          tcge_pkg::ST_GLYPH: begin
            cmd.advance = 1'b1;
            state_next  = tcge_pkg::ST_CUR_END;
          end
          tcge_pkg::ST_HI:     state_next = tcge_pkg::ST_MID;
          tcge_pkg::ST_MID:    state_next = tcge_pkg::ST_LO;
          tcge_pkg::ST_LO: begin
            cmd.advance = 1'b1;
            cmd.adv_two = 1'b1;
            state_next  = tcge_pkg::ST_CUR_END;
          end
          default: begin
            cmd.last   = 1'b1;
            state_next = tcge_pkg::ST_IDLE;
          end
        endcase
      end else begin
        cmd.cnt_inc = 1'b1;
      end
    end
  end

endmodule

// ----- hdl/tcge_dp.sv -----
// Datapath for the text cursor glyph emitter: configuration, cursor, glyph,
// phase counter, byte formation and the output register. Depends on tcge_pkg.
module tcge_dp (
  input  logic               clk,
  input  logic               rst,
  input  logic               cfg_we,
  input  logic               cfg_index,
  input  logic               cfg_data,
  input  logic               opcode,
  input  logic [7:0]         char_code,
  input  logic [63:0]        glyph_bits,
  input  logic [3:0]         target_col,
  input  logic [7:0]         target_row,
  output logic               out_valid,
  input  logic               out_ready,
  output logic               is_data,
  output logic [7:0]         out_byte,
  output logic               last,
  input  tcge_pkg::ctl_cmd_t  cmd,
  output tcge_pkg::ctl_stat_t stat
);

  logic        text_colour_light;
  logic        double_size;
  logic [3:0]  cursor_col;
  logic [7:0]  cursor_row;
  logic [63:0] glyph;
  logic [3:0]  cnt;

  tcge_pkg::kind_t kind;
  logic [7:0]      row_sel;
  logic [3:0]      page;
  logic [7:0]      cur_byte;
  logic [7:0]      raw_byte;
  logic [7:0]      sel_glyph;
  logic [7:0]      sel_pair;
  logic [7:0]      byte_next;
  logic            data_next;
  logic [4:0]      adv_sum;
  logic [3:0]      adv_col;
  logic [7:0]      adv_row;
  logic [1:0]      step;

  always_comb begin
    if (opcode == tcge_pkg::OP_SET) begin
      kind = tcge_pkg::K_SET;
    end else begin
      case (char_code)
        tcge_pkg::CHAR_CR: kind = tcge_pkg::K_CR;
        tcge_pkg::CHAR_LF: kind = tcge_pkg::K_LF;
        tcge_pkg::CHAR_BS: kind = tcge_pkg::K_BS;
        default:           kind = tcge_pkg::K_CHAR;
      endcase
    end
  end

  assign stat.kind     = kind;
  assign stat.col_zero = (cursor_col == 4'd0);
  assign stat.dbl      = double_size;
  assign stat.out_free = !out_valid || out_ready;
  assign stat.cnt      = cnt;

  // Column wrap: past the last text column the column returns to zero and
  // the row moves down by the same step.
  assign step    = cmd.adv_two ? 2'd2 : 2'd1;
  assign adv_sum = {1'b0, cursor_col} + {3'b000, step};
  always_comb begin
    if (adv_sum > 5'(tcge_pkg::TEXT_COLUMNS - 1)) begin
      adv_col = 4'd0;
      adv_row = cursor_row + {6'd0, step};
    end else begin
      adv_col = adv_sum[3:0];
      adv_row = cursor_row;
    end
  end

  assign row_sel = (cmd.src == tcge_pkg::SRC_CURSOR_NEXT) ? cursor_row + 8'd1 : cursor_row;
  assign page    = 4'd7 - row_sel[3:0];

  always_comb begin
    case (cnt[1:0])
      2'd0:    cur_byte = {tcge_pkg::PAGE_BASE, page};
      2'd1:    cur_byte = {tcge_pkg::COL_HI_BASE, 1'b0, cursor_col[3:1]};
      2'd2:    cur_byte = {4'h0, cursor_col[0], 3'b000};
      default: cur_byte = 8'h00;
    endcase
  end

  assign sel_glyph = glyph[8*cnt[2:0] +: 8];
  assign sel_pair  = glyph[8*cnt[3:1] +: 8];

  always_comb begin
    data_next = 1'b1;
    case (cmd.src)
      tcge_pkg::SRC_BLANK: raw_byte = tcge_pkg::BLANK_BYTE;
      tcge_pkg::SRC_GLYPH: raw_byte = sel_glyph;
      tcge_pkg::SRC_HI:    raw_byte = tcge_pkg::dbl_nibble(sel_pair[7:4]);
      tcge_pkg::SRC_LO:    raw_byte = tcge_pkg::dbl_nibble(sel_pair[3:0]);
      default: begin
        raw_byte  = cur_byte;
        data_next = 1'b0;
      end
    endcase
    if (data_next && !text_colour_light) begin
      byte_next = ~raw_byte;
    end else begin
      byte_next = raw_byte;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      text_colour_light <= 1'b1;
      double_size       <= 1'b0;
      cursor_col        <= 4'd0;
      cursor_row        <= 8'd0;
      cnt               <= 4'd0;
      out_valid         <= 1'b0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          tcge_pkg::REG_TEXT_COLOUR: text_colour_light <= cfg_data;
          tcge_pkg::REG_DOUBLE_SIZE: double_size       <= cfg_data;
          default:                   double_size       <= cfg_data;
        endcase
      end
      if (cmd.cnt_clr) begin
        cnt <= 4'd0;
      end else if (cmd.cnt_inc) begin
        cnt <= cnt + 4'd1;
      end
      if (cmd.emit) begin
        out_valid <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
      if (cmd.load) begin
        case (kind)
          tcge_pkg::K_SET: begin
            cursor_col <= target_col;
            cursor_row <= target_row;
          end
          tcge_pkg::K_CR: cursor_col <= 4'd0;
          tcge_pkg::K_LF: cursor_row <= cursor_row + 8'd1;
          tcge_pkg::K_BS: begin
            if (cursor_col != 4'd0) begin
              cursor_col <= cursor_col - 4'd1;
            end
          end
          default: cursor_col <= cursor_col;
        endcase
      end else if (cmd.advance) begin
        cursor_col <= adv_col;
        cursor_row <= adv_row;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      glyph <= glyph_bits;
    end
    if (cmd.emit) begin
      is_data  <= data_next;
      out_byte <= byte_next;
      last     <= cmd.last;
    end
  end

endmodule

// ----- hdl/text_cursor_glyph_emitter.sv -----
// Text cursor glyph emitter for a page-addressed monochrome display.
// Top level: joins tcge_ctrl and tcge_dp; depends on tcge_pkg.
//
// Usage: the input channel (in_valid/in_ready) carries one beat per item:
// a set-cursor request or a character with its 8-byte glyph. The output
// channel (out_valid/out_ready) carries one display byte per beat, flagged
// as command or data, with last marking the final byte of the item.
// Configuration is written through cfg_we/cfg_index/cfg_data; the user must
// write it only while idle, as the block does not enforce this. Throughput:
// one output beat per cycle while the receiver is ready. An item produces 3
// beats (set cursor, CR, LF), 14 (backspace), 11 (character) or 38
// (double-size character), and a backspace at column zero produces none.
// The controller takes the next item in the cycle after loading the final
// byte of the current one into the output register; after acceptance, the
// first byte passes the state register and then the output register.
// A stalled receiver holds the output register, and the sequencer waits
// with it; nothing is dropped. Reset clears the cursor to column 0, row 0,
// sets light text colour, normal size, and empties the output register.
module text_cursor_glyph_emitter (
  input  logic        clk,
  input  logic        rst,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic        cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        opcode,
  input  logic [7:0]  char_code,
  input  logic [63:0] glyph_bits,
  input  logic [3:0]  target_col,
  input  logic [7:0]  target_row,
  output logic        out_valid,
  input  logic        out_ready,
  output logic        is_data,
  output logic [7:0]  out_byte,
  output logic        last
);

  tcge_pkg::ctl_cmd_t  cmd;
  tcge_pkg::ctl_stat_t stat;

  tcge_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_ready (in_ready),
    .stat     (stat),
    .cmd      (cmd)
  );

  tcge_dp u_dp (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .opcode     (opcode),
    .char_code  (char_code),
    .glyph_bits (glyph_bits),
    .target_col (target_col),
    .target_row (target_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_data    (is_data),
    .out_byte   (out_byte),
    .last       (last),
    .cmd        (cmd),
    .stat       (stat)
  );

`ifndef SYNTHESIS
  a_emit_needs_room: assert property (@(posedge clk) disable iff (rst)
    cmd.emit |-> (!out_valid || out_ready))
    else $error("byte emitted while output register was full and stalled");

  a_last_frees_input: assert property (@(posedge clk) disable iff (rst)
    (cmd.emit && cmd.last) |=> in_ready)
    else $error("controller not idle after final byte of an item");

  a_no_emit_on_accept: assert property (@(posedge clk) disable iff (rst)
    (in_valid && in_ready) |-> !cmd.emit)
    else $error("byte emitted in the same cycle an item was accepted");
`endif

endmodule

// ----- tb/sv/text_cursor_glyph_emitter_tb.sv -----
// Self-checking testbench for text_cursor_glyph_emitter: a directed script, then random
// text streams, each checked beat by beat against an in-bench cursor and glyph predictor.
// Depends on tcge_pkg and the text_cursor_glyph_emitter RTL only.
module text_cursor_glyph_emitter_tb;

  localparam logic CMD_BEAT       = 1'b0;
  localparam logic DATA_BEAT      = 1'b1;
  localparam int   WATCHDOG_LIMIT = 2000;
  localparam int   PHASE_ITEMS    = 80;

  typedef struct packed {
    logic       is_data;
    logic [7:0] val;
    logic       last;
  } disp_beat_t;

  typedef struct packed {
    logic        is_cfg;
    logic        cfg_sel;
    logic        cfg_val;
    logic        op;
    logic [7:0]  ch;
    logic [63:0] glyph;
    logic [3:0]  col;
    logic [7:0]  row;
    logic        typed;
    logic [23:0] cmds;
  } script_row_t;

  logic        clk;
  logic        rst;
  logic        cfg_we;
  logic        cfg_index;
  logic        cfg_data;
  logic        in_valid;
  logic        in_ready;
  logic        opcode;
  logic [7:0]  char_code;
  logic [63:0] glyph_bits;
  logic [3:0]  target_col;
  logic [7:0]  target_row;
  logic        out_valid;
  logic        out_ready;
  logic        is_data;
  logic [7:0]  out_byte;
  logic        last;

  text_cursor_glyph_emitter i_dut (
    .clk        (clk),
    .rst        (rst),
    .cfg_we     (cfg_we),
    .cfg_index  (cfg_index),
    .cfg_data   (cfg_data),
    .in_valid   (in_valid),
    .in_ready   (in_ready),
    .opcode     (opcode),
    .char_code  (char_code),
    .glyph_bits (glyph_bits),
    .target_col (target_col),
    .target_row (target_row),
    .out_valid  (out_valid),
    .out_ready  (out_ready),
    .is_data    (is_data),
    .out_byte   (out_byte),
    .last       (last)
  );

  logic [3:0]  cur_col;
  logic [7:0]  cur_row;
  logic        light_text;
  logic        big_text;
  disp_beat_t  burst [38];
  int          burst_n;
  disp_beat_t  expected_beats [$];
  int          mismatches;
  bit          calm;
  int          stall_left;
  int          quiet_cycles;
  script_row_t script [$];

  initial clk = 1'b0;
  always #10 clk = ~clk;

  function automatic logic [7:0] ink(input logic [7:0] b);
    return light_text ? b : ~b;
  endfunction

  function automatic logic [15:0] spread(input logic [7:0] b);
    logic [15:0] z;
    for (int k = 0; k < 8; k++) begin
      z[2*k]   = b[k];
      z[2*k+1] = b[k];
    end
    return z;
  endfunction

  task automatic add_beat(input logic kind, input logic [7:0] val);
    burst[burst_n] = {kind, val, 1'b0};
    burst_n++;
  endtask

  task automatic add_cursor(input logic [3:0] col, input logic [7:0] row);
    logic [7:0] px;
    logic [7:0] page;
    px   = {1'b0, col, 3'b000};
    page = 8'd7 - row;
    add_beat(CMD_BEAT, {tcge_pkg::PAGE_BASE, page[3:0]});
    add_beat(CMD_BEAT, {tcge_pkg::COL_HI_BASE, px[7:4]});
    add_beat(CMD_BEAT, {4'h0, px[3:0]});
  endtask

  // A character moves the cursor by its width; past the last column the row grows by the same.
  task automatic move_cursor(input int step);
    int c;
    c = cur_col + step;
    if (c > tcge_pkg::TEXT_COLUMNS - 1) begin
      c = 0;
      cur_row = cur_row + step[7:0];
    end
    cur_col = c[3:0];
  endtask

  task automatic predict_item(input logic op, input logic [7:0] ch, input logic [63:0] glyph,
                              input logic [3:0] col, input logic [7:0] row);
    logic [15:0] wide;
    burst_n = 0;
    if (op == tcge_pkg::OP_SET) begin
      cur_col = col;
      cur_row = row;
      add_cursor(cur_col, cur_row);
    end else if (ch == tcge_pkg::CHAR_CR) begin
      cur_col = 4'd0;
      add_cursor(cur_col, cur_row);
    end else if (ch == tcge_pkg::CHAR_LF) begin
      cur_row = cur_row + 8'd1;
      add_cursor(cur_col, cur_row);
    end else if (ch == tcge_pkg::CHAR_BS) begin
      if (cur_col != 4'd0) begin
        cur_col = cur_col - 4'd1;
        add_cursor(cur_col, cur_row);
        for (int i = 0; i < 8; i++) add_beat(DATA_BEAT, ink(tcge_pkg::BLANK_BYTE));
        add_cursor(cur_col, cur_row);
      end
    end else if (big_text) begin
      for (int i = 0; i < 8; i++) begin
        wide = spread(glyph[8*i +: 8]);
        add_beat(DATA_BEAT, ink(wide[15:8]));
        add_beat(DATA_BEAT, ink(wide[15:8]));
      end
      add_cursor(cur_col, cur_row + 8'd1);
      for (int i = 0; i < 8; i++) begin
        wide = spread(glyph[8*i +: 8]);
        add_beat(DATA_BEAT, ink(wide[7:0]));
        add_beat(DATA_BEAT, ink(wide[7:0]));
      end
      move_cursor(2);
      add_cursor(cur_col, cur_row);
    end else begin
      for (int i = 0; i < 8; i++) add_beat(DATA_BEAT, ink(glyph[8*i +: 8]));
      move_cursor(1);
      add_cursor(cur_col, cur_row);
    end
    if (burst_n > 0) burst[burst_n-1].last = 1'b1;
  endtask

  task automatic send_item(input logic op, input logic [7:0] ch, input logic [63:0] glyph,
                           input logic [3:0] col, input logic [7:0] row,
                           input logic typed, input logic [23:0] cmds);
    in_valid   <= 1'b1;
    opcode     <= op;
    char_code  <= ch;
    glyph_bits <= glyph;
    target_col <= col;
    target_row <= row;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    predict_item(op, ch, glyph, col, row);
    if (typed) begin
      burst_n  = 3;
      burst[0] = {CMD_BEAT, cmds[23:16], 1'b0};
      burst[1] = {CMD_BEAT, cmds[15:8], 1'b0};
      burst[2] = {CMD_BEAT, cmds[7:0], 1'b1};
    end
    for (int k = 0; k < burst_n; k++) expected_beats.push_back(burst[k]);
  endtask

  task automatic idle_in(input int n);
    in_valid <= 1'b0;
    repeat (n) @(posedge clk);
  endtask

  task automatic drain_out();
    in_valid <= 1'b0;
    do @(posedge clk); while (expected_beats.size() != 0);
  endtask

  task automatic set_register(input logic sel, input logic val);
    drain_out();
    // A backspace at column zero leaves nothing to wait for, so allow the pipeline to settle.
    repeat (10) @(posedge clk);
    cfg_we    <= 1'b1;
    cfg_index <= sel;
    cfg_data  <= val;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (sel == tcge_pkg::REG_TEXT_COLOUR) light_text = val;
    else big_text = val;
  endtask

  function automatic script_row_t item_row(input logic op, input logic [7:0] ch,
                                           input logic [63:0] glyph, input logic [3:0] col,
                                           input logic [7:0] row);
    script_row_t r;
    r       = '0;
    r.op    = op;
    r.ch    = ch;
    r.glyph = glyph;
    r.col   = col;
    r.row   = row;
    return r;
  endfunction

  function automatic script_row_t typed_set_row(input logic [3:0] col, input logic [7:0] row,
                                                input logic [23:0] cmds);
    script_row_t r;
    r       = item_row(tcge_pkg::OP_SET, 8'hFF, '1, col, row);
    r.typed = 1'b1;
    r.cmds  = cmds;
    return r;
  endfunction

  function automatic script_row_t cfg_row(input logic sel, input logic val);
    script_row_t r;
    r         = '0;
    r.is_cfg  = 1'b1;
    r.cfg_sel = sel;
    r.cfg_val = val;
    return r;
  endfunction

  always @(posedge clk) begin
    if (stall_left > 0) begin
      stall_left <= stall_left - 1;
      out_ready  <= 1'b0;
    end else if (!calm && $urandom_range(0, 5) == 0) begin
      stall_left <= $urandom_range(1, 7) - 1;
      out_ready  <= 1'b0;
    end else begin
      out_ready <= 1'b1;
    end
  end

  always @(posedge clk) begin
    disp_beat_t want;
    if (!rst && out_valid && out_ready) begin
      if (expected_beats.size() == 0) begin
        $display("%0t: unexpected beat: expected none, got is_data %0b byte %h last %0b",
                 $time, is_data, out_byte, last);
        mismatches = mismatches + 1;
      end else begin
        want = expected_beats.pop_front();
        if (is_data !== want.is_data) begin
          $display("%0t: is_data expected %0b got %0b", $time, want.is_data, is_data);
          mismatches = mismatches + 1;
        end
        if (out_byte !== want.val) begin
          $display("%0t: out_byte expected %h got %h", $time, want.val, out_byte);
          mismatches = mismatches + 1;
        end
        if (last !== want.last) begin
          $display("%0t: last expected %0b got %0b", $time, want.last, last);
          mismatches = mismatches + 1;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst || (in_valid && in_ready) || (out_valid && out_ready)) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("text_cursor_glyph_emitter_tb failed");
      $finish;
    end
  end

  initial begin
    logic        r_op;
    logic [7:0]  r_ch;
    logic [63:0] r_glyph;
    logic [3:0]  r_col;
    logic [7:0]  r_row;
    logic        want_light;
    logic        want_big;
    int          pick;

    rst        <= 1'b1;
    cfg_we     <= 1'b0;
    cfg_index  <= 1'b0;
    cfg_data   <= 1'b0;
    in_valid   <= 1'b0;
    opcode     <= 1'b0;
    char_code  <= 8'd0;
    glyph_bits <= 64'd0;
    target_col <= 4'd0;
    target_row <= 8'd0;
    out_ready  <= 1'b0;
    stall_left   = 0;
    quiet_cycles = 0;
    mismatches   = 0;
    calm         = 1'b0;
    cur_col      = 4'd0;
    cur_row      = 8'd0;
    light_text   = 1'b1;
    big_text     = 1'b0;

    script.push_back(typed_set_row(4'd0, 8'd0, 24'hB7_10_00));
    script.push_back(typed_set_row(4'd15, 8'd255, 24'hB8_17_08));
    script.push_back(typed_set_row(4'd0, 8'd8, 24'hBF_10_00));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'h41, 64'h0, 4'd5, 8'd3));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'hFF, '1, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'h00, 64'h0123_4567_89AB_CDEF, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'h1B, 64'h8000_0000_0000_0001, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, tcge_pkg::CHAR_BS, '1, 4'd15, 8'd255));
    script.push_back(item_row(tcge_pkg::OP_PUT, tcge_pkg::CHAR_CR, '1, 4'd15, 8'd255));
    script.push_back(item_row(tcge_pkg::OP_PUT, tcge_pkg::CHAR_BS, '0, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, tcge_pkg::CHAR_LF, '0, 4'd0, 8'd0));
    script.push_back(typed_set_row(4'd15, 8'd255, 24'hB8_17_08));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'h7F, 64'hFEDC_BA98_7654_3210, 4'd0, 8'd0));
    script.push_back(cfg_row(tcge_pkg::REG_TEXT_COLOUR, 1'b0));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'h41, 64'h00FF_00FF_55AA_33CC, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, tcge_pkg::CHAR_BS, '0, 4'd0, 8'd0));
    script.push_back(cfg_row(tcge_pkg::REG_DOUBLE_SIZE, 1'b1));
    script.push_back(typed_set_row(4'd14, 8'd7, 24'hB0_17_00));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'h42, 64'hF0F0_0F0F_C3C3_3C3C, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'hFF, '1, 4'd0, 8'd0));
    script.push_back(cfg_row(tcge_pkg::REG_TEXT_COLOUR, 1'b1));
    script.push_back(item_row(tcge_pkg::OP_SET, 8'h00, '0, 4'd13, 8'd254));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'h80, 64'h0123_4567_89AB_CDEF, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'h20, 64'h8142_2418_1824_4281, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, 8'h55, 64'hAA55_AA55_0000_FFFF, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, tcge_pkg::CHAR_BS, '0, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, tcge_pkg::CHAR_LF, '0, 4'd0, 8'd0));
    script.push_back(item_row(tcge_pkg::OP_PUT, tcge_pkg::CHAR_CR, '0, 4'd0, 8'd0));
    script.push_back(cfg_row(tcge_pkg::REG_DOUBLE_SIZE, 1'b0));

    repeat (9) @(posedge clk);
    rst <= 1'b0;

    foreach (script[k]) begin
      if (script[k].is_cfg) begin
        set_register(script[k].cfg_sel, script[k].cfg_val);
      end else begin
        send_item(script[k].op, script[k].ch, script[k].glyph, script[k].col, script[k].row,
                  script[k].typed, script[k].cmds);
      end
    end

    for (int ph = 0; ph < 4; ph++) begin
      want_light = (ph == 0) ? 1'b0 : (ph == 2) ? 1'($urandom_range(0, 1)) : 1'b1;
      want_big   = (ph == 1) ? 1'b1 : (ph == 2) ? 1'($urandom_range(0, 1)) : 1'b0;
      set_register(tcge_pkg::REG_TEXT_COLOUR, want_light);
      set_register(tcge_pkg::REG_DOUBLE_SIZE, want_big);
      for (int n = 0; n < PHASE_ITEMS; n++) begin
        if (ph == 3 && n >= 20) calm = 1'b1;
        if (ph == 1 && n == PHASE_ITEMS / 2) drain_out();
        if (!calm && $urandom_range(0, 3) == 0) idle_in($urandom_range(1, 7));
        pick    = $urandom_range(0, 99);
        r_op    = tcge_pkg::OP_PUT;
        r_ch    = 8'($urandom_range(0, 255));
        r_glyph = {$urandom, $urandom};
        r_col   = 4'($urandom_range(0, 15));
        r_row   = 8'($urandom_range(0, 255));
        if (pick < 14) begin
          r_op = tcge_pkg::OP_SET;
          if (pick < 8) r_row = 8'($urandom_range(0, 9));
        end else if (pick < 22) begin
          r_ch = tcge_pkg::CHAR_CR;
        end else if (pick < 30) begin
          r_ch = tcge_pkg::CHAR_LF;
        end else if (pick < 40) begin
          r_ch = tcge_pkg::CHAR_BS;
        end else if (pick < 44) begin
          r_glyph = (pick < 42) ? '0 : '1;
        end
        send_item(r_op, r_ch, r_glyph, r_col, r_row, 1'b0, 24'd0);
      end
    end

    drain_out();
    repeat (20) @(posedge clk);
    if (mismatches == 0 && expected_beats.size() == 0) begin
      $display("text_cursor_glyph_emitter_tb passed");
    end else begin
      $display("text_cursor_glyph_emitter_tb failed");
    end
    $finish;
  end

endmodule
